FILE: src/pipw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_pkg
// Shared types and constants of the winding-number point-in-polygon block.
// ----------------------------------------------------------------------------
package pipw_pkg;

  // Fixed widths of the channel fields.
  localparam int IDX_W   = 6;
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 7;
  localparam int WIND_W  = 8;

  // Defaults for the top-level parameters.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_OUT
  } pipw_state_t;

  // Status of the edge test pipeline towards the sequencer.
  typedef struct packed {
    logic valid;
    logic inc;
    logic dec;
    logic busy;
  } pipw_edge_stat_t;

endpackage : pipw_pkg
`default_nettype wire

FILE: src/pipw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pipw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : pipw_ram
`default_nettype wire

FILE: src/pipw_edge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_edge
// Three-stage edge test: crossing direction, exact cross product sign, and
// the resulting step of the winding number.
// ----------------------------------------------------------------------------
module pipw_edge
  import pipw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         edge_vld,
  input  wire logic signed [COORD_BITS-1:0] cur_x,
  input  wire logic signed [COORD_BITS-1:0] cur_y,
  input  wire logic signed [COORD_BITS-1:0] nxt_x,
  input  wire logic signed [COORD_BITS-1:0] nxt_y,
  input  wire logic signed [COORD_BITS-1:0] pt_x,
  input  wire logic signed [COORD_BITS-1:0] pt_y,
  output pipw_edge_stat_t                   stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CRW = PW + 1;

  // Stage 1: differences and crossing direction.
  logic                 s1_vld_r;
  logic                 s1_up_r, s1_dn_r;
  logic signed [DW-1:0] s1_dxe_r, s1_dyp_r, s1_dye_r, s1_dxp_r;
  logic signed [DW-1:0] dxe_nxt, dyp_nxt, dye_nxt, dxp_nxt;
  logic                 up_nxt, dn_nxt;

  // Stage 2: the two products.
  logic                 s2_vld_r;
  logic                 s2_up_r, s2_dn_r;
  logic signed [PW-1:0] s2_pa_r, s2_pb_r;
  logic signed [PW-1:0] pa_nxt, pb_nxt;

  // Stage 3: sign of the cross product and the step.
  logic                  res_vld_r, res_inc_r, res_dec_r;
  logic signed [CRW-1:0] cr;
  logic                  cr_pos, cr_neg;

  always_comb begin
    dxe_nxt = DW'(nxt_x) - DW'(cur_x);
    dyp_nxt = DW'(pt_y) - DW'(cur_y);
    dye_nxt = DW'(nxt_y) - DW'(cur_y);
    dxp_nxt = DW'(pt_x) - DW'(cur_x);
    up_nxt  = (cur_y <= pt_y) && (nxt_y > pt_y);
    dn_nxt  = (cur_y > pt_y) && (nxt_y <= pt_y);
  end

  assign pa_nxt = PW'(s1_dxe_r) * PW'(s1_dyp_r);
  assign pb_nxt = PW'(s1_dye_r) * PW'(s1_dxp_r);

  always_comb begin
    cr     = CRW'(s2_pa_r) - CRW'(s2_pb_r);
    cr_neg = cr[CRW-1];
    cr_pos = !cr[CRW-1] && (cr != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= edge_vld;
      s2_vld_r  <= s1_vld_r;
      res_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dxe_r  <= dxe_nxt;
    s1_dyp_r  <= dyp_nxt;
    s1_dye_r  <= dye_nxt;
    s1_dxp_r  <= dxp_nxt;
    s1_up_r   <= up_nxt;
    s1_dn_r   <= dn_nxt;
    s2_pa_r   <= pa_nxt;
    s2_pb_r   <= pb_nxt;
    s2_up_r   <= s1_up_r;
    s2_dn_r   <= s1_dn_r;
    // A zero cross product means the point lies on the edge and never counts.
    res_inc_r <= s2_up_r && cr_pos;
    res_dec_r <= s2_dn_r && cr_neg;
  end

  always_comb begin
    stat.valid = res_vld_r;
    stat.inc   = res_inc_r;
    stat.dec   = res_dec_r;
    stat.busy  = s1_vld_r || s2_vld_r || res_vld_r;
  end

endmodule : pipw_edge
`default_nettype wire

FILE: src/point_in_polygon_winding.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_winding
// Winding-number point-in-polygon test over a polygon held in a vertex RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries load and query transfers. A load writes one
//   vertex into the RAM in the cycle it is accepted, if its index is below
//   MAX_VERTICES, and gives no result. A query walks every edge of the
//   polygon, closing edge included, and gives one result transfer with the
//   winding number and the inside flag. cfg_wr_en/cfg_wr_data set the number
//   of vertices in use; write it only while no query is in progress.
// Timing:
//   A load is accepted without stalling the input. A query holds the input
//   stalled while it walks the polygon: one vertex is read per cycle from
//   the single RAM read port, the last and the closing edge pass through
//   the three-stage edge pipeline into the accumulator, and the result is
//   then loaded into the output register once that register can take it.
//   out_valid rises at the edge where in_stall falls.
// Stalls and reset:
//   A pending result stays in the output register while out_stall is high;
//   loads are still accepted meanwhile, and a finished query waits for the
//   register to empty before it is written. Reset clears the control state
//   and the vertex count but not the RAM: vertices read before being written
//   give no defined answer.
// ----------------------------------------------------------------------------
module point_in_polygon_winding
  import pipw_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic        [COUNT_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_req_type,
  input  wire logic        [IDX_W-1:0]   in_vertex_index,
  input  wire logic signed [FIELD_W-1:0] in_coord_x,
  input  wire logic signed [FIELD_W-1:0] in_coord_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_inside_res,
  output logic signed      [WIND_W-1:0]  out_winding
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int ACCW = CW + 1;
  localparam int VW   = 2 * COORD_BITS;

  pipw_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] cfg_vertex_count_r;

  logic                           in_acc, load_acc, query_acc, slot_ok, mem_we;
  logic [CW-1:0]                  count_lim;
  logic [CW-1:0]                  n_r, cnt_r, cnt_nxt;
  logic signed [COORD_BITS-1:0]   px_r, py_r;
  logic                           rd_en, rd_vld_r, rd_first_r, rd_last_r, close_r;
  logic [VW-1:0]                  wr_data, rd_data;
  logic signed [COORD_BITS-1:0]   rd_x, rd_y;
  logic signed [COORD_BITS-1:0]   first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0]   edge_nx, edge_ny;
  logic                           edge_vld;
  pipw_edge_stat_t                edge_stat;
  logic signed [ACCW-1:0]         acc_r;
  logic signed [31:0]             acc_ext;
  logic signed [WIND_W-1:0]       wind_sat;
  logic                           out_load, out_valid_r, out_inside_res_r;
  logic signed [WIND_W-1:0]       out_winding_r;

  // Input side.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_req_type == REQ_LOAD);
  assign query_acc = in_acc && (in_req_type == REQ_QUERY);
  assign slot_ok   = (32'(in_vertex_index) < 32'(MAX_VERTICES));
  assign mem_we    = load_acc && slot_ok;
  assign wr_data   = {COORD_BITS'(in_coord_x), COORD_BITS'(in_coord_y)};

  assign count_lim = (32'(cfg_vertex_count_r) > 32'(MAX_VERTICES)) ?
                     CW'(MAX_VERTICES) : CW'(cfg_vertex_count_r);

  pipw_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_vertex_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[VW-1:COORD_BITS];
  assign rd_y = rd_data[COORD_BITS-1:0];

  // The closing edge runs from the last vertex back to the first one.
  assign edge_vld = (rd_vld_r && !rd_first_r) || close_r;
  assign edge_nx  = close_r ? first_x_r : rd_x;
  assign edge_ny  = close_r ? first_y_r : rd_y;

  pipw_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_vld (edge_vld),
    .cur_x    (prev_x_r),
    .cur_y    (prev_y_r),
    .nxt_x    (edge_nx),
    .nxt_y    (edge_ny),
    .pt_x     (px_r),
    .pt_y     (py_r),
    .stat     (edge_stat)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          cnt_nxt   = '0;
          state_nxt = (count_lim == '0) ? ST_OUT : ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (cnt_r == n_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !close_r && !edge_stat.busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cfg_vertex_count_r <= '0;
      rd_vld_r           <= 1'b0;
      close_r            <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      close_r  <= rd_vld_r && rd_last_r;
      if (cfg_wr_en) begin
        cfg_vertex_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rd_first_r <= (cnt_r == '0);
    rd_last_r  <= (cnt_r == n_r - CW'(1));
    if (query_acc) begin
      n_r   <= count_lim;
      px_r  <= COORD_BITS'(in_coord_x);
      py_r  <= COORD_BITS'(in_coord_y);
      acc_r <= '0;
    end else if (edge_stat.valid) begin
      if (edge_stat.inc) begin
        acc_r <= acc_r + ACCW'(1);
      end else if (edge_stat.dec) begin
        acc_r <= acc_r - ACCW'(1);
      end
    end
    if (rd_vld_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
      if (rd_first_r) begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
      end
    end
    if (out_load) begin
      out_inside_res_r <= (acc_r != '0);
      out_winding_r    <= wind_sat;
    end
  end

  // Saturate the winding number to the result width.
  always_comb begin
    acc_ext = 32'(acc_r);
    if (acc_ext > 32'sd127) begin
      wind_sat = WIND_W'(32'sd127);
    end else if (acc_ext < -32'sd128) begin
      wind_sat = WIND_W'(-32'sd128);
    end else begin
      wind_sat = WIND_W'(acc_ext);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;
  assign out_winding    = out_winding_r;

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (cnt_r < n_r))
    else $error("vertex read beyond the polygon");

  a_edge_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    edge_stat.valid |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("edge result outside a query walk");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_vld_r && !close_r && !edge_stat.busy))
    else $error("edge pipeline not empty while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");
`endif

endmodule : point_in_polygon_winding
`default_nettype wire
